// ===== src/disparity_hole_fill_box_mean_assert.svh =====
// Assertion macros shared by the hole-fill block.
`ifndef DISPARITY_HOLE_FILL_BOX_MEAN_ASSERT_SVH
`define DISPARITY_HOLE_FILL_BOX_MEAN_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define DHFBM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define DHFBM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/dhfbm_pkg.sv =====
// Package with shared constants and register codes of the hole-fill block.
`timescale 1ns / 1ps
package dhfbm_pkg;
   localparam int DISP_W         = 12;
   localparam int OUT_W          = 16;
   localparam int GEOM_W         = 11;
   localparam int ROW_W          = 10;
   localparam int MAX_HEIGHT     = 1024;
   localparam int DEF_WIDTH      = 640;
   localparam int DEF_HEIGHT     = 480;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int RADIUS_DEF     = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;
endpackage

// ===== src/dhfbm_req_if.sv =====
// Stream interfaces for the input and result channels.
`timescale 1ns / 1ps
interface dhfbm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [dhfbm_pkg::DISP_W-1:0] disparity;
   modport source (output valid, output kind, output disparity, input ready);
   modport sink (input valid, input kind, input disparity, output ready);
endinterface

interface dhfbm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dhfbm_pkg::OUT_W-1:0] filled_disparity;
   logic                               has_support;
   logic                               end_of_line;
   logic                               end_of_frame;
   modport source (output valid, output filled_disparity, output has_support,
                   output end_of_line, output end_of_frame, input ready);
   modport sink (input valid, input filled_disparity, input has_support,
                 input end_of_line, input end_of_frame, output ready);
endinterface

// ===== src/dhfbm_row_mem.sv =====
// Line store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module dhfbm_row_mem import dhfbm_pkg::*; #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DISP_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DISP_W-1:0] rd_data
);
   logic [DISP_W-1:0] mem [2**ADDR_W];
   logic [DISP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/dhfbm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dhfbm_div import dhfbm_pkg::*; #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DEN_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(trial);
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== src/disparity_hole_fill_box_mean.sv =====
// Top level of the disparity hole-fill block: sequencer, counters and config.
// An item that produces no result leaves the block idle, so it is ready for the next item.
// An item with a result holds the input until the result is registered: one store read
// per tap, then, with at least one valid tap, the divider at one quotient bit per divider
// cycle, else the centre value is kept; a full output adds its wait.
// Synchronous active-high reset clears the stream counters and restores 640x480; store not cleared.
`timescale 1ns / 1ps
`include "disparity_hole_fill_box_mean_assert.svh"
module disparity_hole_fill_box_mean import dhfbm_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int RADIUS    = RADIUS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dhfbm_req_if.sink             req_chan,
   dhfbm_rsp_if.source           rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   // Window and store geometry.
   localparam int SPAN   = 2 * RADIUS + 1;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int SW     = $clog2(SPAN);
   localparam int AW     = SW + CW;
   localparam int XW     = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
   localparam int PW     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);
   localparam int SUMW   = $clog2(SPAN * SPAN * 2047 + 1);
   localparam int DIV_W  = SUMW + 4;
   localparam int CNTW   = $clog2(SPAN * SPAN + 1);
   localparam int RW     = ROW_W + 2;
   localparam int CSW    = CW + 2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WIN, ST_LAST, ST_PICK, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [GEOM_W-1:0] frame_width_ff, frame_height_ff;
   logic              csr_write;

   // Stream position counters.
   logic [CW-1:0]    in_col_ff, out_col_ff;
   logic [ROW_W-1:0] in_row_ff, out_row_ff;
   logic [SW-1:0]    in_slot_ff, out_slot_ff;
   logic [PW-1:0]    pending_ff;

   // Window walk.
   logic [SW-1:0]         slot_ff;
   logic [SW-1:0]         dr_ff, dc_ff;
   logic signed [RW-1:0]  r_ff;
   logic signed [CSW-1:0] c_ff, c0_ff;
   logic                  rd_live_ff, rd_ok_ff, rd_center_ff;
   logic [SUMW-1:0]       sum_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic [DISP_W-1:0]     center_ff;
   logic                  eol_ff, eof_ff;
   logic [OUT_W-1:0]      res_ff;

   // Output register.
   logic                    rsp_full_ff;
   logic signed [OUT_W-1:0] rsp_data_ff;
   logic                    rsp_sup_ff, rsp_eol_ff, rsp_eof_ff;

   logic [XW-1:0]     fw_x;
   logic [CW:0]       w_eff;
   logic [ROW_W:0]    h_eff;
   logic [PW-1:0]     thresh;
   logic              accept, emit_pix, emit_flush, emit;
   logic              in_range, mem_wr;
   logic [AW-1:0]     rd_addr;
   logic [DISP_W-1:0] rd_data;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  quotient;
   logic [SW:0]       slot_start;
   logic              rsp_take, rsp_load;

   // Geometry is clamped to what the store and row counters can hold.
   always_comb begin
      fw_x = XW'(frame_width_ff);
      if (fw_x == '0) begin
         w_eff = (CW + 1)'(1);
      end else if (fw_x > XW'(MAX_WIDTH)) begin
         w_eff = (CW + 1)'(MAX_WIDTH);
      end else begin
         w_eff = (CW + 1)'(fw_x);
      end
      if (frame_height_ff == '0) begin
         h_eff = (ROW_W + 1)'(1);
      end else if (frame_height_ff > GEOM_W'(MAX_HEIGHT)) begin
         h_eff = (ROW_W + 1)'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // An output is due once RADIUS rows and RADIUS pixels lie beyond it.
   assign thresh     = PW'(RADIUS) * PW'(w_eff) + PW'(RADIUS);
   assign accept     = req_chan.valid && req_chan.ready;
   assign emit_pix   = (req_chan.kind == KIND_PIXEL) && ((pending_ff + 1'b1) > thresh);
   assign emit_flush = (req_chan.kind == KIND_FLUSH) && (pending_ff != '0)
                       && (in_row_ff == '0) && (in_col_ff == '0);
   assign emit       = emit_pix || emit_flush;
   assign mem_wr     = accept && (req_chan.kind == KIND_PIXEL);
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign slot_start = {1'b0, out_slot_ff} + (SW + 1)'(SPAN - RADIUS);

   // A tap counts only when it lies inside the image.
   assign in_range = (r_ff >= 0) && (r_ff < $signed({1'b0, h_eff}))
                     && (c_ff >= 0) && (c_ff < $signed({1'b0, w_eff}));
   assign rd_addr  = {slot_ff, c_ff[CW-1:0]};

   dhfbm_row_mem #(.ADDR_W(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr ({in_slot_ff, in_col_ff}),
      .wr_data (req_chan.disparity),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_start = (state_ff == ST_PICK) && (cnt_ff != '0);

   dhfbm_div #(.NUM_W(DIV_W), .DEN_W(CNTW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, 4'b0000}),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_full_ff || rsp_chan.ready);

   // Main sequencer: store the pixel, walk the window, divide (or keep the centre), hand over.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pending_ff  <= '0;
         rd_live_ff  <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         rd_live_ff <= (state_ff == ST_WIN);
         if (rsp_load) begin
            rsp_full_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_full_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_chan.kind == KIND_PIXEL) begin
                     if ({1'b0, in_col_ff} + 1'b1 >= w_eff) begin
                        in_col_ff  <= '0;
                        in_slot_ff <= (in_slot_ff == SW'(SPAN - 1)) ? '0 : in_slot_ff + 1'b1;
                        in_row_ff  <= ({1'b0, in_row_ff} + 1'b1 >= h_eff)
                                      ? '0 : in_row_ff + 1'b1;
                     end else begin
                        in_col_ff <= in_col_ff + 1'b1;
                     end
                     if (!emit_pix) begin
                        pending_ff <= pending_ff + 1'b1;
                     end
                  end else if (emit_flush) begin
                     pending_ff <= pending_ff - 1'b1;
                  end
                  if (emit) begin
                     // Snapshot the output position, then move it on.
                     state_ff <= ST_WIN;
                     if ({1'b0, out_col_ff} + 1'b1 >= w_eff) begin
                        out_col_ff  <= '0;
                        out_slot_ff <= (out_slot_ff == SW'(SPAN - 1))
                                       ? '0 : out_slot_ff + 1'b1;
                        out_row_ff  <= ({1'b0, out_row_ff} + 1'b1 >= h_eff)
                                       ? '0 : out_row_ff + 1'b1;
                     end else begin
                        out_col_ff <= out_col_ff + 1'b1;
                     end
                  end
               end
            end
            ST_WIN: begin
               if (dr_ff == SW'(SPAN - 1) && dc_ff == SW'(SPAN - 1)) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_PICK;
            end
            ST_PICK: begin
               state_ff <= (cnt_ff != '0) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Window datapath: addresses, in-range tags and the running sum and count.
   always_ff @(posedge clock) begin
      rd_ok_ff     <= in_range;
      rd_center_ff <= (dr_ff == SW'(RADIUS)) && (dc_ff == SW'(RADIUS));
      if (state_ff == ST_IDLE) begin
         slot_ff <= (slot_start >= (SW + 1)'(SPAN)) ? SW'(slot_start - (SW + 1)'(SPAN))
                                                   : SW'(slot_start);
         r_ff    <= $signed(RW'(out_row_ff)) - RW'(RADIUS);
         c_ff    <= $signed(CSW'(out_col_ff)) - CSW'(RADIUS);
         c0_ff   <= $signed(CSW'(out_col_ff)) - CSW'(RADIUS);
         dr_ff   <= '0;
         dc_ff   <= '0;
         sum_ff  <= '0;
         cnt_ff  <= '0;
         eol_ff  <= ({1'b0, out_col_ff} == w_eff - 1'b1);
         eof_ff  <= ({1'b0, out_col_ff} == w_eff - 1'b1)
                    && ({1'b0, out_row_ff} == h_eff - 1'b1);
      end else if (state_ff == ST_WIN) begin
         if (dc_ff == SW'(SPAN - 1)) begin
            dc_ff   <= '0;
            c_ff    <= c0_ff;
            dr_ff   <= dr_ff + 1'b1;
            r_ff    <= r_ff + 1'b1;
            slot_ff <= (slot_ff == SW'(SPAN - 1)) ? '0 : slot_ff + 1'b1;
         end else begin
            dc_ff <= dc_ff + 1'b1;
            c_ff  <= c_ff + 1'b1;
         end
      end
      if (rd_live_ff) begin
         if (rd_ok_ff && !rd_data[DISP_W-1] && rd_data != '0) begin
            sum_ff <= sum_ff + SUMW'(rd_data[DISP_W-2:0]);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rd_center_ff) begin
            center_ff <= rd_data;
         end
      end
      if (state_ff == ST_PICK && cnt_ff == '0) begin
         res_ff <= {center_ff, 4'b0000};
      end else if (state_ff == ST_DIV && div_done) begin
         res_ff <= quotient[OUT_W-1:0];
      end
      if (rsp_load) begin
         rsp_data_ff <= $signed(res_ff);
         rsp_sup_ff  <= (cnt_ff != '0);
         rsp_eol_ff  <= eol_ff;
         rsp_eof_ff  <= eof_ff;
      end
   end

   assign rsp_chan.valid            = rsp_full_ff;
   assign rsp_chan.filled_disparity = rsp_data_ff;
   assign rsp_chan.has_support      = rsp_sup_ff;
   assign rsp_chan.end_of_line      = rsp_eol_ff;
   assign rsp_chan.end_of_frame     = rsp_eof_ff;

   // Configuration port: two registers at byte offsets 0 and 4.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= GEOM_W'(DEF_WIDTH);
         frame_height_ff <= GEOM_W'(DEF_HEIGHT);
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_pwdata[GEOM_W-1:0];
         end else begin
            frame_height_ff <= csr_pwdata[GEOM_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_FRAME_HEIGHT)
                       ? CSR_DATA_W'(frame_height_ff) : CSR_DATA_W'(frame_width_ff);

   // A waiting result stays put until the receiver takes it.
   `DHFBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_data_ff), "waiting result changed")
   // The divider is only started with at least one valid tap.
   `DHFBM_ASSERT_NOW(a_div_nonzero, clock, reset, div_start, cnt_ff != '0, "divide by zero count")
   // A finished result is always moved into the output register.
   `DHFBM_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_full_ff && state_ff == ST_IDLE, "result not registered")
endmodule
